// ===== design/dca_pkg.sv =====
// ----------------------------------------------------------------------------
// dca_pkg
// Shared types and codes for the descriptor chain allocator.
// ----------------------------------------------------------------------------
package dca_pkg;

    // request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_REBUILD = 2'd2
    } req_t;

    // result status carried in the output tuser
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_LEN  = 2'd1,
        STAT_OVERFILL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_REBUILD,
        S_REPLY
    } state_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  alloc_head;
        logic [8:0]  free_count;
    } result_t;

    localparam logic [8:0] QUEUE_ENTRIES_RST = 9'd256;

endpackage

// ===== design/dca_ram.sv =====
// ----------------------------------------------------------------------------
// dca_ram
// Generic single-write, single-read synchronous RAM, registered read data,
// read returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module dca_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/dca_ctrl.sv =====
// ----------------------------------------------------------------------------
// dca_ctrl
// Request sequencer: walks descriptor chains in the link memory one entry
// per cycle, keeps the free list head and free count, runs the rebuild sweep.
// ----------------------------------------------------------------------------
module dca_ctrl
    import dca_pkg::*;
#(
    parameter int DESC_COUNT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [8:0] chain_length,
    input  logic [7:0] chain_head,
    input  logic [8:0] queue_entries,
    input  logic       out_free,
    output logic       out_load,
    output result_t    out_res
);

    localparam int IDX_W = $clog2(DESC_COUNT);
    localparam int CNT_W = $clog2(DESC_COUNT + 2);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W + 1 : 10;
    localparam int ENT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] RST_N_EFF =
        CNT_W'((DESC_COUNT < 256) ? DESC_COUNT : 256);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DESC_COUNT - 1);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] list_head_reg, list_head_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] chead_reg, chead_next;
    logic [8:0]       remain_reg, remain_next;
    logic [8:0]       len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] sweep_idx_reg, sweep_idx_next;
    logic [CNT_W-1:0] sweep_n_reg, sweep_n_next;
    result_t          res_reg, res_next;
    logic             fwd_hit_reg, fwd_hit_next;
    logic [ENT_W-1:0] fwd_data_reg, fwd_data_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;

    logic [IDX_W-1:0] mod_tab [256];
    logic [CNT_W-1:0] n_eff;
    logic [ENT_W-1:0] ent;
    logic [IDX_W-1:0] ent_next;
    logic             ent_cont;
    logic             alloc_bad;
    logic             alloc_more;
    logic             free_more;
    logic             free_over;
    logic             sweep_last;
    logic [CNT_W-1:0] sweep_succ;
    logic             fin;
    result_t          res_comb;

    // index reduction table for the chain head of a free request
    for (genvar g = 0; g < 256; g++)
    begin : g_mod
        assign mod_tab[g] = IDX_W'(g % DESC_COUNT);
    end

    dca_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DESC_COUNT)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (queue_entries == 9'd0 ||
            CMP_W'(queue_entries) > CMP_W'(DESC_COUNT))
        begin
            n_eff = CNT_W'(DESC_COUNT);
        end
        else
        begin
            n_eff = CNT_W'(queue_entries);
        end
    end

    // entry fields, with forwarding of a same-cycle write to the read address
    assign ent        = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign ent_next   = ent[IDX_W-1:0];
    assign ent_cont   = ent[ENT_W-1];

    assign alloc_bad  = (chain_length == 9'd0) ||
                        (CMP_W'(chain_length) > CMP_W'(free_reg));
    assign alloc_more = (remain_reg != 9'd0);
    assign free_more  = ent_cont && (cnt_reg <= n_eff);
    assign free_over  = (CMP_W'(free_reg) + CMP_W'(cnt_reg)) > CMP_W'(n_eff);
    assign sweep_last = (sweep_idx_reg == LAST_IDX);
    assign sweep_succ = CNT_W'(sweep_idx_reg) + CNT_W'(1);

    assign in_ready   = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type)
                        REQ_ALLOC:
                        begin
                            if (alloc_bad)
                            begin
                                state_next = out_free ? S_IDLE : S_REPLY;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        REQ_FREE:    state_next = S_FREE;
                        REQ_REBUILD: state_next = S_REBUILD;
                        default:     state_next = out_free ? S_IDLE : S_REPLY;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (!alloc_more)
                begin
                    state_next = out_free ? S_IDLE : S_REPLY;
                end
            end
            S_FREE:
            begin
                if (!free_more)
                begin
                    state_next = out_free ? S_IDLE : S_REPLY;
                end
            end
            S_REBUILD:
            begin
                if (sweep_last)
                begin
                    state_next = out_free ? S_IDLE : S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        list_head_next = list_head_reg;
        free_next      = free_reg;
        cur_next       = cur_reg;
        head_next      = head_reg;
        chead_next     = chead_reg;
        remain_next    = remain_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        sweep_idx_next = sweep_idx_reg;
        sweep_n_next   = sweep_n_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = cur_reg;
        fin            = 1'b0;
        res_comb       = '{status: STAT_OK, alloc_head: 8'd0, free_count: 9'(free_reg)};
        out_load       = 1'b0;
        out_res        = res_reg;

        unique case (state_reg)
            S_INIT, S_REBUILD:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_idx_reg;
                if (sweep_succ < sweep_n_reg)
                begin
                    wr_data = {1'b1, IDX_W'(sweep_succ)};
                end
                if (sweep_last)
                begin
                    list_head_next      = '0;
                    free_next           = sweep_n_reg;
                    res_comb.free_count = 9'(sweep_n_reg);
                    fin                 = (state_reg == S_REBUILD);
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type)
                        REQ_ALLOC:
                        begin
                            if (alloc_bad)
                            begin
                                res_comb.status = STAT_BAD_LEN;
                                fin             = 1'b1;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = list_head_reg;
                                cur_next    = list_head_reg;
                                head_next   = list_head_reg;
                                remain_next = chain_length - 9'd1;
                                len_next    = chain_length;
                            end
                        end
                        REQ_FREE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = mod_tab[chain_head];
                            cur_next   = mod_tab[chain_head];
                            chead_next = mod_tab[chain_head];
                            cnt_next   = CNT_W'(1);
                        end
                        REQ_REBUILD:
                        begin
                            sweep_idx_next = '0;
                            sweep_n_next   = n_eff;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                if (alloc_more)
                begin
                    wr_data     = {1'b1, ent_next};
                    rd_en       = 1'b1;
                    rd_addr     = ent_next;
                    cur_next    = ent_next;
                    remain_next = remain_reg - 9'd1;
                end
                else
                begin
                    // last entry of the chain ends it
                    wr_data             = {1'b0, ent_next};
                    list_head_next      = ent_next;
                    free_next           = free_reg - CNT_W'(len_reg);
                    res_comb.alloc_head = 8'(head_reg);
                    res_comb.free_count = 9'(free_reg - CNT_W'(len_reg));
                    fin                 = 1'b1;
                end
            end
            S_FREE:
            begin
                if (free_more)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ent_next;
                    cur_next = ent_next;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    fin = 1'b1;
                    if (free_over)
                    begin
                        res_comb.status = STAT_OVERFILL;
                    end
                    else
                    begin
                        // splice the chain tail onto the free head
                        wr_en               = 1'b1;
                        wr_addr             = cur_reg;
                        wr_data             = {ent_cont, list_head_reg};
                        list_head_next      = chead_reg;
                        free_next           = free_reg + cnt_reg;
                        res_comb.free_count = 9'(free_reg + cnt_reg);
                    end
                end
            end
            S_REPLY:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            out_load = out_free;
            out_res  = res_comb;
            res_next = res_comb;
        end
    end

    assign fwd_hit_next  = wr_en && rd_en && (wr_addr == rd_addr);
    assign fwd_data_next = wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            list_head_reg <= '0;
            free_reg      <= RST_N_EFF;
            sweep_idx_reg <= '0;
            sweep_n_reg   <= RST_N_EFF;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_reg      <= free_next;
            sweep_idx_reg <= sweep_idx_next;
            sweep_n_reg   <= sweep_n_next;
            fwd_hit_reg   <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        head_reg     <= head_next;
        chead_reg    <= chead_next;
        remain_reg   <= remain_next;
        len_reg      <= len_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

// ===== design/descriptor_chain_allocator.sv =====
// ----------------------------------------------------------------------------
// descriptor_chain_allocator
// Linked free list of descriptor entries with allocate, free and rebuild.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser holds the request kind
// (allocate, free, rebuild), tdata the chain length and the chain head.
// Every request gives exactly one result on the m_axis channel: tuser holds
// the status, tdata the allocated head and the free count after the request.
// The user must write queue_entries on the cfg channel only while no
// request is in flight; the block does not enforce this. The value is used
// by the next rebuild and by the free walk. Refused allocates and unknown
// kinds are answered from the idle state; an allocate or a free walks its
// chain, one link memory read per entry walked. A rebuild sweeps every
// entry of the link memory; reset runs the same sweep with s_axis_tready low.
// The result sits in an output register; a new request is taken while it
// waits, and the next result holds in the sequencer until m_axis_tready.
// ----------------------------------------------------------------------------
module descriptor_chain_allocator
    import dca_pkg::*;
#(
    parameter int DESC_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // chain_length[8:0], chain_head[16:9]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // alloc_head[7:0], free_count[16:8]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data        // queue_entries[8:0]
);

    logic [8:0] queue_entries_reg;
    logic       m_valid_reg, m_valid_next;
    result_t    m_res_reg;
    logic       out_free;
    logic       out_load;
    result_t    out_res;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_axis_tready;

    dca_ctrl #(
        .DESC_COUNT (DESC_COUNT)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .req_type      (s_axis_tuser),
        .chain_length  (s_axis_tdata[8:0]),
        .chain_head    (s_axis_tdata[16:9]),
        .queue_entries (queue_entries_reg),
        .out_free      (out_free),
        .out_load      (out_load),
        .out_res       (out_res)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_entries_reg <= QUEUE_ENTRIES_RST;
            m_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                queue_entries_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_res_reg <= out_res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tdata  = {7'd0, m_res_reg.free_count, m_res_reg.alloc_head};

endmodule

// ===== design/dca_checker.sv =====
// ----------------------------------------------------------------------------
// dca_checker
// Port-level checks of the descriptor chain allocator, bound to the top.
// ----------------------------------------------------------------------------
module dca_checker
    import dca_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic [1:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // requests taken whose result has not been taken yet
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tdata[7:0] == 8'd0)
        else $error("refused request returned a chain head");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 2'd0)
        else $error("result without a pending request");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pending_reg != 2'd2)
        else $error("request taken with two results outstanding");

endmodule

bind descriptor_chain_allocator dca_checker u_dca_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
